>>> rtl/core/pbps_pkg.sv
// Package with operation codes, component codes and state types of the buffer pool selector.
`timescale 1ns / 1ps
package pbps_pkg;

  localparam logic [3:0] OP_ALLOC    = 4'd0;
  localparam logic [3:0] OP_RELEASE  = 4'd1;
  localparam logic [3:0] OP_DESCRIBE = 4'd2;
  localparam logic [3:0] OP_SENT     = 4'd3;
  localparam logic [3:0] OP_RECEIVED = 4'd4;
  localparam logic [3:0] OP_ADV      = 4'd5;
  localparam logic [3:0] OP_SYNC     = 4'd6;
  localparam logic [3:0] OP_SHARED   = 4'd7;
  localparam logic [3:0] OP_DEDIC    = 4'd8;
  localparam logic [3:0] OP_TIMEOUT  = 4'd9;
  localparam logic [3:0] OP_TXREPORT = 4'd10;

  localparam logic [3:0] COMP_NONE  = 4'd0;
  localparam logic [3:0] COMP_POOL  = 4'd1;
  localparam logic [3:0] COMP_MAC   = 4'd2;
  localparam logic [3:0] COMP_UPPER = 4'd3;

  localparam int unsigned ASN_W = 40;

  localparam logic [2:0] REG_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_MINBE   = 3'd1;
  localparam logic [2:0] REG_MAXBE   = 3'd2;
  localparam logic [2:0] REG_ADV     = 3'd3;
  localparam logic [2:0] REG_SYNC    = 3'd4;
  localparam logic [2:0] REG_ALIASRQ = 3'd5;
  localparam logic [2:0] REG_ALIASEN = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DONE = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

endpackage

>>> rtl/core/packet_buffer_pool_selector_unit.sv
// Top level of the packet buffer pool selector: slot descriptors, scan sequencer and APB registers.
`timescale 1ns / 1ps
// From acceptance of a request, a single compare unit walks the descriptors
// one slot per cycle, then a commit step updates the pool, then the result is held until
// taken. Release, describe and tx report also go through the walk so that every request
// has the same latency. The next request can be accepted in the cycle after the result
// has been taken, so a new request is not taken while one is in flight; a stalled
// result delays the next request. No clearing pass after reset.
module packet_buffer_pool_selector_unit #(
  parameter int unsigned QUEUE_SLOTS = 16,
  parameter int unsigned ADDR_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  operation_i,
  input  logic [3:0]  slot_i,
  input  logic [3:0]  component_i,
  input  logic [39:0] cur_asn_i,
  input  logic [15:0] random_value_i,
  input  logic [ADDR_BITS-1:0] address_i,
  input  logic [7:0]  type_code_i,
  input  logic [7:0]  net_code_i,
  input  logic [2:0]  mac_kind_i,
  input  logic [3:0]  flags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [3:0]  result_slot_o,
  output logic [4:0]  free_count_o
);

  localparam int unsigned IW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(QUEUE_SLOTS + 1);

  // Configuration registers.
  logic [15:0] timeout_q;
  logic [2:0]  minbe_q, maxbe_q, adv_q, sync_q;
  logic [7:0]  aliasrq_q, aliasen_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 16'd1500;
      minbe_q   <= 3'd2;
      maxbe_q   <= 3'd4;
      adv_q     <= 3'd1;
      sync_q    <= 3'd2;
      aliasrq_q <= 8'd1;
      aliasen_q <= 8'd2;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pbps_pkg::REG_TIMEOUT: timeout_q <= pwdata[15:0];
        pbps_pkg::REG_MINBE:   minbe_q   <= pwdata[2:0];
        pbps_pkg::REG_MAXBE:   maxbe_q   <= pwdata[2:0];
        pbps_pkg::REG_ADV:     adv_q     <= pwdata[2:0];
        pbps_pkg::REG_SYNC:    sync_q    <= pwdata[2:0];
        pbps_pkg::REG_ALIASRQ: aliasrq_q <= pwdata[7:0];
        pbps_pkg::REG_ALIASEN: aliasen_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      pbps_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_q};
      pbps_pkg::REG_MINBE:   prdata = {29'd0, minbe_q};
      pbps_pkg::REG_MAXBE:   prdata = {29'd0, maxbe_q};
      pbps_pkg::REG_ADV:     prdata = {29'd0, adv_q};
      pbps_pkg::REG_SYNC:    prdata = {29'd0, sync_q};
      pbps_pkg::REG_ALIASRQ: prdata = {24'd0, aliasrq_q};
      pbps_pkg::REG_ALIASEN: prdata = {24'd0, aliasen_q};
      default: prdata = '0;
    endcase
  end

  // Slot descriptors. Each is read at the scan index or, at commit, at the request slot.
  logic [3:0]  own_q   [QUEUE_SLOTS];
  logic [3:0]  crt_q   [QUEUE_SLOTS];
  logic [39:0] asn_q   [QUEUE_SLOTS];
  logic [3:0]  flg_q   [QUEUE_SLOTS];
  logic [2:0]  mk_q    [QUEUE_SLOTS];
  logic [7:0]  pt_q    [QUEUE_SLOTS];
  logic [7:0]  nv_q    [QUEUE_SLOTS];
  logic [ADDR_BITS-1:0] hop_q [QUEUE_SLOTS];
  logic [2:0]  be_q    [QUEUE_SLOTS];
  logic [7:0]  bo_q    [QUEUE_SLOTS];
  logic [CW-1:0] free_q;

  // Latched request.
  logic [3:0]  op_q, slot_q, comp_q, fl_q;
  logic [39:0] casn_q;
  logic [15:0] rnd_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [7:0]  tc_q, nc_q;
  logic [2:0]  mkin_q;

  pbps_pkg::state_e state_q;
  logic [IW-1:0] idx_q;
  logic          hit_q;
  logic [IW-1:0] hidx_q;
  logic          found_q;
  logic [3:0]    rslot_q;

  logic accept, last, match, slot_ok;
  logic [IW-1:0] s_idx;
  logic [39:0] age;
  logic bcast_ok, tmd;

  assign in_stall_o  = (state_q != pbps_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == pbps_pkg::ST_OUT);
  assign found_o       = found_q;
  assign result_slot_o = rslot_q;
  assign free_count_o  = 5'(free_q);
  assign last    = (32'(idx_q) == QUEUE_SLOTS - 1);
  assign slot_ok = (32'(slot_q) < QUEUE_SLOTS);
  assign s_idx   = IW'(slot_q);

  // Shared compare unit: evaluates the current operation against slot idx_q.
  assign tmd = (own_q[idx_q] == pbps_pkg::COMP_MAC) && flg_q[idx_q][0];
  assign age = casn_q - asn_q[idx_q];
  always_comb begin
    bcast_ok = tmd && crt_q[idx_q] == pbps_pkg::COMP_UPPER && flg_q[idx_q][2];
    match = 1'b0;
    case (op_q)
      pbps_pkg::OP_ALLOC:    match = (own_q[idx_q] == pbps_pkg::COMP_NONE);
      pbps_pkg::OP_SENT:     match = (own_q[idx_q] == pbps_pkg::COMP_UPPER)
                                     && (crt_q[idx_q] != pbps_pkg::COMP_MAC);
      pbps_pkg::OP_RECEIVED: match = (own_q[idx_q] == pbps_pkg::COMP_UPPER)
                                     && (crt_q[idx_q] == pbps_pkg::COMP_MAC);
      pbps_pkg::OP_ADV:      match = bcast_ok && mk_q[idx_q] == adv_q;
      pbps_pkg::OP_SYNC:     match = bcast_ok && mk_q[idx_q] == sync_q;
      pbps_pkg::OP_SHARED:   match = tmd && flg_q[idx_q][1] && bo_q[idx_q] == 8'd0
                                     && nv_q[idx_q] == nc_q
                                     && (fl_q[0] || hop_q[idx_q] == addr_q)
                                     && !flg_q[idx_q][2];
      pbps_pkg::OP_DEDIC:    match = tmd && !flg_q[idx_q][1]
                                     && (pt_q[idx_q] == tc_q
                                         || (tc_q == aliasrq_q && pt_q[idx_q] == aliasen_q))
                                     && hop_q[idx_q] == addr_q && !flg_q[idx_q][2];
      pbps_pkg::OP_TIMEOUT:  match = (crt_q[idx_q] != pbps_pkg::COMP_NONE
                                      || own_q[idx_q] != pbps_pkg::COMP_NONE)
                                     && age >= {24'd0, timeout_q};
      default:               match = 1'b0;
    endcase
  end

  logic alloc_ok;
  assign alloc_ok = fl_q[0] || (comp_q <= pbps_pkg::COMP_MAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbps_pkg::ST_IDLE;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      free_q  <= CW'(QUEUE_SLOTS);
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        own_q[i] <= pbps_pkg::COMP_NONE;
        crt_q[i] <= pbps_pkg::COMP_NONE;
        flg_q[i] <= '0;
        mk_q[i]  <= '0;
        pt_q[i]  <= '0;
        be_q[i]  <= 3'd2;
        bo_q[i]  <= '0;
      end
    end else begin
      case (state_q)
        pbps_pkg::ST_IDLE: begin
          if (accept) begin
            idx_q   <= '0;
            hit_q   <= 1'b0;
            state_q <= pbps_pkg::ST_SCAN;
          end
        end
        pbps_pkg::ST_SCAN: begin
          // Shared lookup keeps the last match; the others keep the first.
          if (match && (!hit_q || op_q == pbps_pkg::OP_SHARED)) begin
            hit_q  <= 1'b1;
            hidx_q <= idx_q;
          end
          if (op_q == pbps_pkg::OP_SHARED && !match && bo_q[idx_q] != 8'd0) begin
            bo_q[idx_q] <= bo_q[idx_q] - 8'd1;
          end
          if (last) state_q <= pbps_pkg::ST_DONE;
          else      idx_q <= idx_q + IW'(1);
        end
        pbps_pkg::ST_DONE: begin
          state_q <= pbps_pkg::ST_OUT;
          case (op_q)
            pbps_pkg::OP_ALLOC: begin
              if (alloc_ok && hit_q) begin
                own_q[hidx_q] <= pbps_pkg::COMP_POOL;
                crt_q[hidx_q] <= comp_q;
                asn_q[hidx_q] <= casn_q;
                if (free_q != '0) free_q <= free_q - CW'(1);
              end
            end
            pbps_pkg::OP_RELEASE: begin
              if (slot_ok && own_q[s_idx] != pbps_pkg::COMP_NONE
                  && crt_q[s_idx] != pbps_pkg::COMP_NONE) begin
                own_q[s_idx] <= pbps_pkg::COMP_NONE;
                crt_q[s_idx] <= pbps_pkg::COMP_NONE;
                flg_q[s_idx] <= '0;
                mk_q[s_idx]  <= '0;
                pt_q[s_idx]  <= '0;
                be_q[s_idx]  <= minbe_q;
                bo_q[s_idx]  <= '0;
                if (32'(free_q) < QUEUE_SLOTS) free_q <= free_q + CW'(1);
              end
            end
            pbps_pkg::OP_DESCRIBE: begin
              if (slot_ok && own_q[s_idx] != pbps_pkg::COMP_NONE
                  && comp_q != pbps_pkg::COMP_NONE) begin
                own_q[s_idx] <= comp_q;
                hop_q[s_idx] <= addr_q;
                pt_q[s_idx]  <= tc_q;
                nv_q[s_idx]  <= nc_q;
                mk_q[s_idx]  <= mkin_q;
                flg_q[s_idx] <= fl_q;
              end
            end
            pbps_pkg::OP_TXREPORT: begin
              if (slot_ok) begin
                if (fl_q[0]) begin
                  be_q[s_idx] <= minbe_q;
                  bo_q[s_idx] <= '0;
                end else begin
                  logic [2:0] ne;
                  ne = (be_q[s_idx] < maxbe_q) ? be_q[s_idx] + 3'd1 : be_q[s_idx];
                  be_q[s_idx] <= ne;
                  bo_q[s_idx] <= rnd_q[7:0] & 8'((16'd1 << ne) - 16'd1);
                end
              end
            end
            default: ;
          endcase
        end
        pbps_pkg::ST_OUT: begin
          if (!out_stall_i) state_q <= pbps_pkg::ST_IDLE;
        end
        default: state_q <= pbps_pkg::ST_IDLE;
      endcase
    end
  end

  // Request latch and result register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      slot_q <= slot_i;
      comp_q <= component_i;
      casn_q <= cur_asn_i;
      rnd_q  <= random_value_i;
      addr_q <= address_i;
      tc_q   <= type_code_i;
      nc_q   <= net_code_i;
      mkin_q <= mac_kind_i;
      fl_q   <= flags_i;
    end
    if (state_q == pbps_pkg::ST_DONE) begin
      found_q <= 1'b0;
      rslot_q <= 4'd0;
      case (op_q)
        pbps_pkg::OP_ALLOC: begin
          found_q <= alloc_ok && hit_q;
          rslot_q <= (alloc_ok && hit_q) ? 4'(hidx_q) : 4'd0;
        end
        pbps_pkg::OP_RELEASE: begin
          if (slot_ok && own_q[s_idx] != pbps_pkg::COMP_NONE
              && crt_q[s_idx] != pbps_pkg::COMP_NONE) begin
            found_q <= 1'b1;
            rslot_q <= slot_q;
          end
        end
        pbps_pkg::OP_DESCRIBE: begin
          if (slot_ok && own_q[s_idx] != pbps_pkg::COMP_NONE
              && comp_q != pbps_pkg::COMP_NONE) begin
            found_q <= 1'b1;
            rslot_q <= slot_q;
          end
        end
        pbps_pkg::OP_TXREPORT: begin
          found_q <= slot_ok;
          rslot_q <= slot_ok ? slot_q : 4'd0;
        end
        default: begin
          found_q <= hit_q;
          rslot_q <= hit_q ? 4'(hidx_q) : 4'd0;
        end
      endcase
    end
  end

  // Free count never exceeds the pool size.
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_q) <= QUEUE_SLOTS) else $error("free count out of range");
  // A result is offered only after the commit cycle.
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == pbps_pkg::ST_DONE)
    else $error("result without commit");
  // A result without a match always reports slot 0.
  a_slot_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> result_slot_o == 4'd0)
    else $error("slot reported without match");

endmodule
